@@ hdl/wsp_pkg.sv @@
package wsp_pkg;

   // configuration register file
   localparam int unsigned CSR_ADDR_W        = 3;
   localparam int unsigned CSR_DATA_W        = 32;
   localparam int unsigned SAMPLE_RATE_W     = 31;
   localparam logic [SAMPLE_RATE_W-1:0] SAMPLE_RATE_RESET = 31'd16000;
   localparam logic REG_SAMPLE_RATE          = 1'b0;   // register index, paddr[2]

   // result queue
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned QUEUE_PTR_W  = 1;
   localparam int unsigned QUEUE_CNT_W  = 2;

   // header constants
   localparam logic [7:0]  CHAR_R   = 8'h52;
   localparam logic [7:0]  CHAR_I   = 8'h49;
   localparam logic [7:0]  CHAR_F   = 8'h46;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;   // "WAVE" little-endian
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;   // "fmt "
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;   // "data"
   localparam logic [31:0] FMT_BASE_LEN    = 32'd16;
   localparam logic [15:0] FORMAT_PCM      = 16'd1;
   localparam logic [15:0] MAX_CHANNELS    = 16'd2;    // first count rejected
   localparam logic [15:0] BLOCK_ALIGN     = 16'd2;
   localparam logic [15:0] BITS_PER_SAMPLE = 16'd16;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_ERROR  = 1'b1;

   typedef enum logic [3:0] {
      ERR_NONE   = 4'd0,
      ERR_WAVE   = 4'd1,
      ERR_FMT    = 4'd2,
      ERR_PCM    = 4'd3,
      ERR_CHAN   = 4'd4,
      ERR_RATE   = 4'd5,
      ERR_BRATE  = 4'd6,
      ERR_ALIGN  = 4'd7,
      ERR_BITS   = 4'd8
   } err_type;

   typedef enum logic [4:0] {
      PH_IDLE        = 5'd0,
      PH_MAGIC       = 5'd1,
      PH_RAW         = 5'd2,
      PH_RAW_PEND    = 5'd3,
      PH_RIFFSIZE    = 5'd4,
      PH_WAVE        = 5'd5,
      PH_FMT         = 5'd6,
      PH_FMTLEN      = 5'd7,
      PH_FORMAT      = 5'd8,
      PH_CHAN        = 5'd9,
      PH_RATE        = 5'd10,
      PH_BRATE       = 5'd11,
      PH_ALIGN       = 5'd12,
      PH_BITS        = 5'd13,
      PH_FMTSKIP     = 5'd14,
      PH_CHID        = 5'd15,
      PH_CHLEN_OTHER = 5'd16,
      PH_CHLEN_DATA  = 5'd17,
      PH_CHSKIP      = 5'd18,
      PH_DATA        = 5'd19
   } phase_type;

   // one result transaction as it travels through the queue
   typedef struct packed {
      logic               raw_mode;
      logic [3:0]         error_code;
      logic signed [15:0] sample;
      logic               kind;
   } rsp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // expected byte of the "RIFF" magic at a given position
   function automatic logic [7:0] magic_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0:    c = CHAR_R;
         2'd1:    c = CHAR_I;
         default: c = CHAR_F;
      endcase
      return c;
   endfunction

endpackage

@@ hdl/wsp_queue.sv @@
module wsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wsp_pkg::rsp_item_type     push_item,
   input  logic                      pop,
   output wsp_pkg::rsp_item_type     head_item,
   output wsp_pkg::queue_status_type status
);

   wsp_pkg::rsp_item_type                 mem_ff [wsp_pkg::QUEUE_DEPTH];
   logic [wsp_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [wsp_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [wsp_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = mem_ff[rd_ptr_ff];
   assign status    = '{full:  (count_ff == wsp_pkg::QUEUE_CNT_W'(wsp_pkg::QUEUE_DEPTH)),
                        empty: (count_ff == '0)};

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wsp_pkg::QUEUE_CNT_W'(wsp_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");
`endif

endmodule

@@ hdl/wsp_front.sv @@
module wsp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   input  logic                              req_tuser,
   input  logic [wsp_pkg::SAMPLE_RATE_W-1:0] sample_rate,
   input  wsp_pkg::queue_status_type         q_status,
   output logic                              push,
   output wsp_pkg::rsp_item_type             push_item
);

   wsp_pkg::phase_type phase_ff, phase_in, eff_phase;
   logic [1:0]   fbi_ff, fbi_in, eff_fbi;
   logic [31:0]  shift_ff, shift_in, eff_shift;
   logic [31:0]  skip_ff, skip_in, eff_skip, skip_dec;
   logic [30:0]  sl_ff, sl_in, eff_sl, sl_dec;
   logic [7:0]   held_ff, held_in, eff_held;
   logic         bp_ff, bp_in, eff_bp;
   logic         hl_ff, hl_in, eff_hl;

   logic         accept;
   logic         fs;
   logic [7:0]   b;
   logic [31:0]  field_val;
   logic         long_field, short_field, field_done;
   logic         emit;
   wsp_pkg::rsp_item_type item;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign fs         = req_tuser;
   assign b          = req_tdata;

   // restart view of the state on a file start byte
   always_comb begin
      eff_phase = fs ? wsp_pkg::PH_MAGIC : phase_ff;
      eff_fbi   = fs ? 2'd0  : fbi_ff;
      eff_shift = fs ? '0    : shift_ff;
      eff_skip  = fs ? '0    : skip_ff;
      eff_sl    = fs ? '0    : sl_ff;
      eff_held  = fs ? '0    : held_ff;
      eff_bp    = fs ? 1'b0  : bp_ff;
      eff_hl    = fs ? 1'b0  : hl_ff;
   end

   // header field assembly, little-endian
   always_comb begin
      field_val   = eff_shift | ({24'd0, b} << {eff_fbi, 3'b000});
      long_field  = (eff_phase == wsp_pkg::PH_RIFFSIZE) || (eff_phase == wsp_pkg::PH_WAVE) ||
                    (eff_phase == wsp_pkg::PH_FMT) || (eff_phase == wsp_pkg::PH_FMTLEN) ||
                    (eff_phase == wsp_pkg::PH_RATE) || (eff_phase == wsp_pkg::PH_BRATE) ||
                    (eff_phase == wsp_pkg::PH_CHID) ||
                    (eff_phase == wsp_pkg::PH_CHLEN_OTHER) ||
                    (eff_phase == wsp_pkg::PH_CHLEN_DATA);
      short_field = (eff_phase == wsp_pkg::PH_FORMAT) || (eff_phase == wsp_pkg::PH_CHAN) ||
                    (eff_phase == wsp_pkg::PH_ALIGN) || (eff_phase == wsp_pkg::PH_BITS);
      field_done  = long_field ? (eff_fbi == 2'd3) : (eff_fbi != 2'd0);
      skip_dec    = (eff_skip != '0) ? eff_skip - 32'd1 : eff_skip;
      sl_dec      = (eff_sl != '0) ? eff_sl - 31'd1 : eff_sl;
   end

   // parser next state and result
   always_comb begin
      phase_in = eff_phase;
      fbi_in   = eff_fbi;
      shift_in = eff_shift;
      skip_in  = eff_skip;
      sl_in    = eff_sl;
      held_in  = eff_held;
      bp_in    = eff_bp;
      hl_in    = eff_hl;
      emit     = 1'b0;
      item     = '0;

      if (long_field || short_field) begin
         fbi_in   = field_done ? 2'd0 : eff_fbi + 2'd1;
         shift_in = field_done ? '0 : field_val;
      end

      unique case (eff_phase)
         wsp_pkg::PH_MAGIC: begin
            if (b == wsp_pkg::magic_char(eff_fbi)) begin
               if (eff_fbi == 2'd3) begin
                  fbi_in   = 2'd0;
                  phase_in = wsp_pkg::PH_RIFFSIZE;
               end else begin
                  fbi_in = eff_fbi + 2'd1;
               end
            end else begin
               hl_in  = 1'b1;
               fbi_in = 2'd0;
               unique case (eff_fbi)
                  2'd0: begin
                     held_in  = b;
                     bp_in    = 1'b1;
                     phase_in = wsp_pkg::PH_RAW;
                  end
                  2'd1: begin
                     bp_in       = 1'b0;
                     phase_in    = wsp_pkg::PH_RAW;
                     emit        = 1'b1;
                     item.sample = {wsp_pkg::CHAR_R, b};
                  end
                  2'd2: begin
                     held_in     = b;
                     bp_in       = 1'b1;
                     phase_in    = wsp_pkg::PH_RAW;
                     emit        = 1'b1;
                     item.sample = {wsp_pkg::CHAR_R, wsp_pkg::CHAR_I};
                  end
                  default: begin
                     held_in     = b;
                     phase_in    = wsp_pkg::PH_RAW_PEND;
                     emit        = 1'b1;
                     item.sample = {wsp_pkg::CHAR_R, wsp_pkg::CHAR_I};
                  end
               endcase
            end
         end
         wsp_pkg::PH_RAW: begin
            if (!eff_bp) begin
               held_in = b;
               bp_in   = 1'b1;
            end else begin
               bp_in       = 1'b0;
               emit        = 1'b1;
               item.sample = {eff_held, b};
            end
         end
         wsp_pkg::PH_RAW_PEND: begin
            held_in     = b;
            bp_in       = 1'b1;
            phase_in    = wsp_pkg::PH_RAW;
            emit        = 1'b1;
            item.sample = {wsp_pkg::CHAR_F, eff_held};
         end
         wsp_pkg::PH_RIFFSIZE: begin
            if (field_done) phase_in = wsp_pkg::PH_WAVE;
         end
         wsp_pkg::PH_WAVE: begin
            if (field_done) begin
               if (field_val != wsp_pkg::TAG_WAVE) begin
                  emit = 1'b1;
                  item.error_code = wsp_pkg::ERR_WAVE;
               end else begin
                  phase_in = wsp_pkg::PH_FMT;
               end
            end
         end
         wsp_pkg::PH_FMT: begin
            if (field_done) begin
               if (field_val != wsp_pkg::TAG_FMT) begin
                  emit = 1'b1;
                  item.error_code = wsp_pkg::ERR_FMT;
               end else begin
                  phase_in = wsp_pkg::PH_FMTLEN;
               end
            end
         end
         wsp_pkg::PH_FMTLEN: begin
            if (field_done) begin
               skip_in  = (field_val > wsp_pkg::FMT_BASE_LEN) ?
                          field_val - wsp_pkg::FMT_BASE_LEN : '0;
               phase_in = wsp_pkg::PH_FORMAT;
            end
         end
         wsp_pkg::PH_FORMAT: begin
            if (field_done) begin
               if (field_val[15:0] != wsp_pkg::FORMAT_PCM) begin
                  emit = 1'b1;
                  item.error_code = wsp_pkg::ERR_PCM;
               end else begin
                  phase_in = wsp_pkg::PH_CHAN;
               end
            end
         end
         wsp_pkg::PH_CHAN: begin
            if (field_done) begin
               if (field_val[15:0] >= wsp_pkg::MAX_CHANNELS) begin
                  emit = 1'b1;
                  item.error_code = wsp_pkg::ERR_CHAN;
               end else begin
                  phase_in = wsp_pkg::PH_RATE;
               end
            end
         end
         wsp_pkg::PH_RATE: begin
            if (field_done) begin
               if (field_val != {1'b0, sample_rate}) begin
                  emit = 1'b1;
                  item.error_code = wsp_pkg::ERR_RATE;
               end else begin
                  phase_in = wsp_pkg::PH_BRATE;
               end
            end
         end
         wsp_pkg::PH_BRATE: begin
            if (field_done) begin
               if (field_val != {sample_rate, 1'b0}) begin
                  emit = 1'b1;
                  item.error_code = wsp_pkg::ERR_BRATE;
               end else begin
                  phase_in = wsp_pkg::PH_ALIGN;
               end
            end
         end
         wsp_pkg::PH_ALIGN: begin
            if (field_done) begin
               if (field_val[15:0] != wsp_pkg::BLOCK_ALIGN) begin
                  emit = 1'b1;
                  item.error_code = wsp_pkg::ERR_ALIGN;
               end else begin
                  phase_in = wsp_pkg::PH_BITS;
               end
            end
         end
         wsp_pkg::PH_BITS: begin
            if (field_done) begin
               if (field_val[15:0] != wsp_pkg::BITS_PER_SAMPLE) begin
                  emit = 1'b1;
                  item.error_code = wsp_pkg::ERR_BITS;
               end else begin
                  phase_in = (eff_skip != '0) ? wsp_pkg::PH_FMTSKIP : wsp_pkg::PH_CHID;
               end
            end
         end
         wsp_pkg::PH_FMTSKIP, wsp_pkg::PH_CHSKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) phase_in = wsp_pkg::PH_CHID;
         end
         wsp_pkg::PH_CHID: begin
            if (field_done) begin
               phase_in = (field_val == wsp_pkg::TAG_DATA) ?
                          wsp_pkg::PH_CHLEN_DATA : wsp_pkg::PH_CHLEN_OTHER;
            end
         end
         wsp_pkg::PH_CHLEN_OTHER: begin
            if (field_done) begin
               skip_in  = field_val;
               phase_in = (field_val != '0) ? wsp_pkg::PH_CHSKIP : wsp_pkg::PH_CHID;
            end
         end
         wsp_pkg::PH_CHLEN_DATA: begin
            if (field_done) begin
               sl_in    = field_val[31:1];
               bp_in    = 1'b0;
               phase_in = (field_val[31:1] != '0) ? wsp_pkg::PH_DATA : wsp_pkg::PH_IDLE;
            end
         end
         wsp_pkg::PH_DATA: begin
            if (!eff_bp) begin
               held_in = b;
               bp_in   = 1'b1;
            end else begin
               bp_in       = 1'b0;
               sl_in       = sl_dec;
               if (sl_dec == '0) phase_in = wsp_pkg::PH_IDLE;
               emit        = 1'b1;
               item.sample = {b, eff_held};
            end
         end
         default: begin
         end
      endcase

      // a header error ends the file
      if (item.error_code != wsp_pkg::ERR_NONE) begin
         item.kind = wsp_pkg::KIND_ERROR;
         phase_in  = wsp_pkg::PH_IDLE;
      end else begin
         item.raw_mode = hl_in;
      end

      // a new file flushes the pending headerless sample instead
      if (fs && (phase_ff == wsp_pkg::PH_RAW_PEND)) begin
         emit          = 1'b1;
         item          = '0;
         item.sample   = {wsp_pkg::CHAR_F, held_ff};
         item.raw_mode = hl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsp_pkg::PH_IDLE;
         fbi_ff   <= '0;
         shift_ff <= '0;
         skip_ff  <= '0;
         sl_ff    <= '0;
         held_ff  <= '0;
         bp_ff    <= 1'b0;
         hl_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         fbi_ff   <= fbi_in;
         shift_ff <= shift_in;
         skip_ff  <= skip_in;
         sl_ff    <= sl_in;
         held_ff  <= held_in;
         bp_ff    <= bp_in;
         hl_ff    <= hl_in;
      end
   end

   assign push      = accept && emit;
   assign push_item = item;

`ifndef ASSERT_OFF
   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      (push && push_item.kind == wsp_pkg::KIND_ERROR) |=> (phase_ff == wsp_pkg::PH_IDLE))
      else $error("parser still active after header error");
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (push && push_item.kind == wsp_pkg::KIND_ERROR) |->
         (push_item.sample == '0 && !push_item.raw_mode &&
          push_item.error_code != wsp_pkg::ERR_NONE))
      else $error("malformed error report");
`endif

endmodule

@@ hdl/wsp_back.sv @@
module wsp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  wsp_pkg::queue_status_type q_status,
   input  wsp_pkg::rsp_item_type     head_item,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [23:0]               rsp_tdata,
   output logic [1:0]                rsp_tuser
);

   logic                  valid_ff, valid_in;
   wsp_pkg::rsp_item_type out_ff;

   // refill the output register whenever it is empty or being taken
   assign pop      = !q_status.empty && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= head_item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.error_code, out_ff.sample};
   assign rsp_tuser  = {out_ff.raw_mode, out_ff.kind};

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!valid_ff || rsp_tready))
      else $error("output register overwritten while stalled");
`endif

endmodule

@@ hdl/wav_stream_parser.sv @@
// Channel  Dir  Fields (tdata / tuser, lowest bit first)
// req      in   tdata: byte_value[7:0]            tuser: file_start
// rsp      out  tdata: sample[15:0], error_code[19:16], zero[23:20]
//                                                 tuser: kind, raw_mode
// csr      in   APB, reg 0 at 0x0: sample_rate[30:0]
//
// One byte per cycle sustained while the result queue is not full.
// The byte parser decides every result in the accept cycle; a 2-entry
// queue and the output register sit behind it.
// Synchronous active-high reset clears all control state; no init pass.
// A stalled rsp side fills the queue, then req_tready drops.
module wav_stream_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // byte_value
   input  logic                           req_tuser,   // file_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // sample, error_code, pad
   output logic [1:0]                     rsp_tuser,   // kind, raw_mode
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [wsp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wsp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wsp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   logic [wsp_pkg::SAMPLE_RATE_W-1:0] sample_rate_ff, sample_rate_in;
   logic                              csr_wr;
   logic                              csr_hit;

   logic                      push;
   logic                      pop;
   wsp_pkg::rsp_item_type     push_item;
   wsp_pkg::rsp_item_type     head_item;
   wsp_pkg::queue_status_type q_status;

   // register file
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == wsp_pkg::REG_SAMPLE_RATE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign sample_rate_in = (csr_wr && csr_hit) ?
                           csr_pwdata[wsp_pkg::SAMPLE_RATE_W-1:0] : sample_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= wsp_pkg::SAMPLE_RATE_RESET;
      end else begin
         sample_rate_ff <= sample_rate_in;
      end
   end

   assign csr_prdata = csr_hit ? {1'b0, sample_rate_ff} : '0;

   wsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .sample_rate (sample_rate_ff),
      .q_status    (q_status),
      .push        (push),
      .push_item   (push_item)
   );

   wsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   wsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ dv/tb_wav_stream_parser.sv @@
module tb_wav_stream_parser;

   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned NUM_PHASES   = 6;
   localparam logic [wsp_pkg::CSR_ADDR_W-1:0] RATE_ADDR = {wsp_pkg::REG_SAMPLE_RATE, 2'b00};
   // "RIFF" as it arrives, first byte in the low bits
   localparam logic [31:0] RIFF_WORD = {wsp_pkg::CHAR_F, wsp_pkg::CHAR_F,
                                        wsp_pkg::CHAR_I, wsp_pkg::CHAR_R};

   typedef struct packed {
      logic [7:0] value;
      logic       start;
   } byte_item_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = 8'h00;   // byte_value
   logic                           req_tuser = 1'b0;    // file_start
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [23:0]                    rsp_tdata;           // sample, error_code, pad
   logic [1:0]                     rsp_tuser;           // kind, raw_mode
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [wsp_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [wsp_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [wsp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   wav_stream_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // bookkeeping
   byte_item_type          byte_stream[$];
   wsp_pkg::rsp_item_type  outputs_due[$];
   int unsigned   fail_count = 0;
   int unsigned   bytes_queued = 0;
   int unsigned   samples_seen = 0;
   int unsigned   errors_seen = 0;
   int unsigned   wave_files = 0;
   int unsigned   raw_files = 0;
   logic          byte_taken = 1'b0;

   // parser shadow state
   wsp_pkg::phase_type  cur_phase;
   logic [1:0]          fld_pos;
   logic [31:0]         fld_acc;
   logic [31:0]         skip_count;
   logic [30:0]         pcm_remaining;
   logic [7:0]          low_byte;
   logic                have_half;
   logic                is_raw;
   logic [wsp_pkg::SAMPLE_RATE_W-1:0] rate_cfg;

   function automatic void restart_parser();
      cur_phase     = wsp_pkg::PH_MAGIC;
      fld_pos       = '0;
      fld_acc       = '0;
      skip_count    = '0;
      pcm_remaining = '0;
      low_byte      = '0;
      have_half     = 1'b0;
      is_raw        = 1'b0;
   endfunction

   function automatic void post_result(input logic kind, input logic [15:0] smp,
                                       input wsp_pkg::err_type code);
      wsp_pkg::rsp_item_type r;
      r.kind       = kind;
      r.sample     = smp;
      r.error_code = code;
      r.raw_mode   = (kind == wsp_pkg::KIND_ERROR) ? 1'b0 : is_raw;
      outputs_due.push_back(r);
   endfunction

   function automatic void reject(input wsp_pkg::err_type code);
      cur_phase = wsp_pkg::PH_IDLE;
      post_result(wsp_pkg::KIND_ERROR, 16'h0000, code);
   endfunction

   // little-endian header field assembly; 1 when the field is complete
   function automatic logic collect_field(input logic [7:0] b, input int unsigned nbytes,
                                          output logic [31:0] v);
      fld_acc = fld_acc | ({24'h0, b} << (8 * fld_pos));
      v = fld_acc;
      if (int'(fld_pos) + 1 >= nbytes) begin
         fld_acc = '0;
         fld_pos = '0;
         return 1'b1;
      end
      fld_pos = fld_pos + 2'd1;
      return 1'b0;
   endfunction

   function automatic void advance_parser(input logic [7:0] b);
      logic [31:0] v;
      logic [7:0]  magic_c;
      case (cur_phase)
         wsp_pkg::PH_MAGIC: begin
            magic_c = RIFF_WORD[8*fld_pos +: 8];
            if (b == magic_c) begin
               if (fld_pos == 2'd3) begin
                  fld_pos   = '0;
                  cur_phase = wsp_pkg::PH_RIFFSIZE;
               end else begin
                  fld_pos = fld_pos + 2'd1;
               end
            end else begin
               // not RIFF: the bytes so far become big-endian samples
               is_raw = 1'b1;
               case (fld_pos)
                  2'd0: begin
                     low_byte  = b;
                     have_half = 1'b1;
                     cur_phase = wsp_pkg::PH_RAW;
                  end
                  2'd1: begin
                     have_half = 1'b0;
                     cur_phase = wsp_pkg::PH_RAW;
                     post_result(wsp_pkg::KIND_SAMPLE, {wsp_pkg::CHAR_R, b}, wsp_pkg::ERR_NONE);
                  end
                  2'd2: begin
                     low_byte  = b;
                     have_half = 1'b1;
                     cur_phase = wsp_pkg::PH_RAW;
                     post_result(wsp_pkg::KIND_SAMPLE, {wsp_pkg::CHAR_R, wsp_pkg::CHAR_I},
                                 wsp_pkg::ERR_NONE);
                  end
                  default: begin
                     low_byte  = b;
                     cur_phase = wsp_pkg::PH_RAW_PEND;
                     post_result(wsp_pkg::KIND_SAMPLE, {wsp_pkg::CHAR_R, wsp_pkg::CHAR_I},
                                 wsp_pkg::ERR_NONE);
                  end
               endcase
               fld_pos = '0;
            end
         end
         wsp_pkg::PH_RAW: begin
            if (!have_half) begin
               low_byte  = b;
               have_half = 1'b1;
            end else begin
               have_half = 1'b0;
               post_result(wsp_pkg::KIND_SAMPLE, {low_byte, b}, wsp_pkg::ERR_NONE);
            end
         end
         wsp_pkg::PH_RAW_PEND: begin
            post_result(wsp_pkg::KIND_SAMPLE, {wsp_pkg::CHAR_F, low_byte}, wsp_pkg::ERR_NONE);
            low_byte  = b;
            have_half = 1'b1;
            cur_phase = wsp_pkg::PH_RAW;
         end
         wsp_pkg::PH_RIFFSIZE: begin
            if (collect_field(b, 4, v)) cur_phase = wsp_pkg::PH_WAVE;
         end
         wsp_pkg::PH_WAVE: begin
            if (collect_field(b, 4, v)) begin
               if (v != wsp_pkg::TAG_WAVE) reject(wsp_pkg::ERR_WAVE);
               else cur_phase = wsp_pkg::PH_FMT;
            end
         end
         wsp_pkg::PH_FMT: begin
            if (collect_field(b, 4, v)) begin
               if (v != wsp_pkg::TAG_FMT) reject(wsp_pkg::ERR_FMT);
               else cur_phase = wsp_pkg::PH_FMTLEN;
            end
         end
         wsp_pkg::PH_FMTLEN: begin
            if (collect_field(b, 4, v)) begin
               skip_count = (v > wsp_pkg::FMT_BASE_LEN) ? v - wsp_pkg::FMT_BASE_LEN : 32'h0;
               cur_phase  = wsp_pkg::PH_FORMAT;
            end
         end
         wsp_pkg::PH_FORMAT: begin
            if (collect_field(b, 2, v)) begin
               if (v != {16'h0, wsp_pkg::FORMAT_PCM}) reject(wsp_pkg::ERR_PCM);
               else cur_phase = wsp_pkg::PH_CHAN;
            end
         end
         wsp_pkg::PH_CHAN: begin
            if (collect_field(b, 2, v)) begin
               if (v >= {16'h0, wsp_pkg::MAX_CHANNELS}) reject(wsp_pkg::ERR_CHAN);
               else cur_phase = wsp_pkg::PH_RATE;
            end
         end
         wsp_pkg::PH_RATE: begin
            if (collect_field(b, 4, v)) begin
               if (v != {1'b0, rate_cfg}) reject(wsp_pkg::ERR_RATE);
               else cur_phase = wsp_pkg::PH_BRATE;
            end
         end
         wsp_pkg::PH_BRATE: begin
            if (collect_field(b, 4, v)) begin
               if (v != {rate_cfg, 1'b0}) reject(wsp_pkg::ERR_BRATE);
               else cur_phase = wsp_pkg::PH_ALIGN;
            end
         end
         wsp_pkg::PH_ALIGN: begin
            if (collect_field(b, 2, v)) begin
               if (v != {16'h0, wsp_pkg::BLOCK_ALIGN}) reject(wsp_pkg::ERR_ALIGN);
               else cur_phase = wsp_pkg::PH_BITS;
            end
         end
         wsp_pkg::PH_BITS: begin
            if (collect_field(b, 2, v)) begin
               if (v != {16'h0, wsp_pkg::BITS_PER_SAMPLE}) reject(wsp_pkg::ERR_BITS);
               else cur_phase = (skip_count != 0) ? wsp_pkg::PH_FMTSKIP : wsp_pkg::PH_CHID;
            end
         end
         wsp_pkg::PH_FMTSKIP, wsp_pkg::PH_CHSKIP: begin
            if (skip_count != 0) skip_count = skip_count - 32'd1;
            if (skip_count == 0) cur_phase = wsp_pkg::PH_CHID;
         end
         wsp_pkg::PH_CHID: begin
            if (collect_field(b, 4, v))
               cur_phase = (v == wsp_pkg::TAG_DATA) ? wsp_pkg::PH_CHLEN_DATA :
                                                      wsp_pkg::PH_CHLEN_OTHER;
         end
         wsp_pkg::PH_CHLEN_OTHER: begin
            if (collect_field(b, 4, v)) begin
               skip_count = v;
               cur_phase  = (v != 0) ? wsp_pkg::PH_CHSKIP : wsp_pkg::PH_CHID;
            end
         end
         wsp_pkg::PH_CHLEN_DATA: begin
            if (collect_field(b, 4, v)) begin
               pcm_remaining = v[31:1];
               have_half     = 1'b0;
               cur_phase     = (v[31:1] != 0) ? wsp_pkg::PH_DATA : wsp_pkg::PH_IDLE;
            end
         end
         wsp_pkg::PH_DATA: begin
            if (!have_half) begin
               low_byte  = b;
               have_half = 1'b1;
            end else begin
               have_half = 1'b0;
               if (pcm_remaining != 0) pcm_remaining = pcm_remaining - 31'd1;
               if (pcm_remaining == 0) cur_phase = wsp_pkg::PH_IDLE;
               post_result(wsp_pkg::KIND_SAMPLE, {b, low_byte}, wsp_pkg::ERR_NONE);
            end
         end
         default: ;
      endcase
   endfunction

   // one accepted byte; a pending headerless sample is flushed on file start
   function automatic void parse_byte(input logic [7:0] b, input logic start);
      int unsigned n0;
      logic        flushed;
      flushed = 1'b0;
      if (start) begin
         if (cur_phase == wsp_pkg::PH_RAW_PEND) begin
            post_result(wsp_pkg::KIND_SAMPLE, {wsp_pkg::CHAR_F, low_byte}, wsp_pkg::ERR_NONE);
            flushed = 1'b1;
         end
         restart_parser();
      end
      n0 = outputs_due.size();
      advance_parser(b);
      if (flushed && outputs_due.size() > n0) outputs_due.delete(outputs_due.size() - 1);
   endfunction

   // idle lengths: mostly short, a few long
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // byte driver
   int unsigned req_wait = 0;
   int unsigned req_run = 0;
   logic        req_calm = 1'b0;

   always @(negedge clock) begin
      byte_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || byte_taken) begin
         if (req_wait > 0) begin
            req_wait = req_wait - 1;
            req_tvalid <= 1'b0;
         end else if (byte_stream.size() != 0) begin
            it = byte_stream.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.value;
            req_tuser  <= it.start;
            if (req_run == 0) begin
               req_run  = $urandom_range(30, 200);
               req_calm = ($urandom_range(0, 2) == 0);
            end else begin
               req_run = req_run - 1;
            end
            req_wait = (!req_calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   int unsigned rsp_stall = 0;
   int unsigned rsp_run = 0;
   logic        rsp_calm = 1'b0;

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_run == 0) begin
            rsp_run  = $urandom_range(30, 200);
            rsp_calm = ($urandom_range(0, 2) == 0);
         end else begin
            rsp_run = rsp_run - 1;
         end
         if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_stall = pick_gap();
      end
   end

   // monitor: check results first, then predict from the accepted byte
   always @(posedge clock) begin
      wsp_pkg::rsp_item_type got;
      wsp_pkg::rsp_item_type want;
      if (reset) begin
         byte_taken <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind       = rsp_tuser[0];
            got.raw_mode   = rsp_tuser[1];
            got.sample     = rsp_tdata[15:0];
            got.error_code = rsp_tdata[19:16];
            if (got.kind == wsp_pkg::KIND_ERROR) errors_seen++;
            else samples_seen++;
            if (outputs_due.size() == 0) begin
               $error("unexpected result transaction: kind %0d sample %h error_code %0d",
                      got.kind, got.sample, got.error_code);
               fail_count++;
            end else begin
               want = outputs_due.pop_front();
               if (got.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, got.kind);
                  fail_count++;
               end
               if (got.sample !== want.sample) begin
                  $error("sample: expected %h, got %h", want.sample, got.sample);
                  fail_count++;
               end
               if (got.error_code !== want.error_code) begin
                  $error("error_code: expected %0d, got %0d", want.error_code,
                         got.error_code);
                  fail_count++;
               end
               if (got.raw_mode !== want.raw_mode) begin
                  $error("raw_mode: expected %0d, got %0d", want.raw_mode, got.raw_mode);
                  fail_count++;
               end
            end
         end
         byte_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tuser);
      end
   end

   // stimulus helpers
   task automatic put_byte(input logic [7:0] v, input logic start);
      byte_item_type it;
      it.value = v;
      it.start = start;
      byte_stream.push_back(it);
      bytes_queued++;
   endtask

   task automatic put_word(input logic [31:0] v, input int unsigned nbytes);
      for (int unsigned k = 0; k < nbytes; k++) put_byte(v[8*k +: 8], 1'b0);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] flip_bit();
      return 32'h1 << $urandom_range(0, 31);
   endfunction

   function automatic logic [15:0] bad_half(input logic [15:0] good);
      logic [15:0] v;
      v = 16'($urandom);
      if ($urandom_range(0, 1) == 0 || v == good) v = good ^ (16'h1 << $urandom_range(0, 15));
      return v;
   endfunction

   // RIFF file, possibly with one broken header field
   task automatic gen_wave_file(input logic [wsp_pkg::SAMPLE_RATE_W-1:0] rate);
      wsp_pkg::err_type flaw;
      int unsigned fmt_len;
      int unsigned clen;
      int unsigned dmode;
      int unsigned dbytes;
      logic [31:0] dlen;
      logic [31:0] id;
      logic [15:0] half;
      wave_files++;
      flaw = wsp_pkg::ERR_NONE;
      if ($urandom_range(0, 2) == 0)
         flaw = wsp_pkg::err_type'($urandom_range(int'(wsp_pkg::ERR_WAVE),
                                                  int'(wsp_pkg::ERR_BITS)));
      put_byte(wsp_pkg::CHAR_R, 1'b1);
      put_byte(wsp_pkg::CHAR_I, 1'b0);
      put_byte(wsp_pkg::CHAR_F, 1'b0);
      put_byte(wsp_pkg::CHAR_F, 1'b0);
      put_word($urandom, 4);
      put_word((flaw == wsp_pkg::ERR_WAVE) ? wsp_pkg::TAG_WAVE ^ flip_bit() :
                                             wsp_pkg::TAG_WAVE, 4);
      put_word((flaw == wsp_pkg::ERR_FMT) ? wsp_pkg::TAG_FMT ^ flip_bit() :
                                            wsp_pkg::TAG_FMT, 4);
      case ($urandom_range(0, 3))
         0:       fmt_len = $urandom_range(0, 15);
         1:       fmt_len = $urandom_range(17, 22);
         default: fmt_len = 16;
      endcase
      put_word(fmt_len, 4);
      half = (flaw == wsp_pkg::ERR_PCM) ? bad_half(wsp_pkg::FORMAT_PCM) : wsp_pkg::FORMAT_PCM;
      put_word({16'h0, half}, 2);
      if (flaw == wsp_pkg::ERR_CHAN)
         half = ($urandom_range(0, 2) == 0) ? wsp_pkg::MAX_CHANNELS :
                                              16'($urandom_range(2, 16'hFFFF));
      else
         half = 16'($urandom_range(0, 1));
      put_word({16'h0, half}, 2);
      put_word((flaw == wsp_pkg::ERR_RATE) ? {1'b0, rate} ^ flip_bit() : {1'b0, rate}, 4);
      put_word((flaw == wsp_pkg::ERR_BRATE) ? {rate, 1'b0} ^ flip_bit() : {rate, 1'b0}, 4);
      half = (flaw == wsp_pkg::ERR_ALIGN) ? bad_half(wsp_pkg::BLOCK_ALIGN) :
                                            wsp_pkg::BLOCK_ALIGN;
      put_word({16'h0, half}, 2);
      half = (flaw == wsp_pkg::ERR_BITS) ? bad_half(wsp_pkg::BITS_PER_SAMPLE) :
                                           wsp_pkg::BITS_PER_SAMPLE;
      put_word({16'h0, half}, 2);
      if (flaw != wsp_pkg::ERR_NONE) begin
         // the rest of the file is ignored by the parser
         repeat ($urandom_range(0, 6)) put_byte(pick_byte(), 1'b0);
         return;
      end
      // extra fmt bytes
      if (fmt_len > 16) repeat (fmt_len - 16) put_byte(pick_byte(), 1'b0);
      // chunks to skip ahead of the data chunk
      repeat ($urandom_range(0, 2)) begin
         id = ($urandom_range(0, 3) == 0) ? wsp_pkg::TAG_DATA ^ flip_bit() : $urandom;
         if (id == wsp_pkg::TAG_DATA) id = id ^ 32'h1;
         put_word(id, 4);
         clen = $urandom_range(0, 6);
         put_word(clen, 4);
         repeat (clen) put_byte(pick_byte(), 1'b0);
      end
      put_word(wsp_pkg::TAG_DATA, 4);
      dmode = $urandom_range(0, 9);
      case (dmode)
         0:       dlen = 32'h0;
         1:       dlen = 32'h1;
         2:       dlen = $urandom | 32'h8000_0000;
         default: dlen = $urandom_range(2, 40);
      endcase
      put_word(dlen, 4);
      if (dmode == 2) begin
         dbytes = $urandom_range(0, 12);
      end else begin
         case ($urandom_range(0, 6))
            0:       dbytes = dlen + $urandom_range(1, 3);
            1:       dbytes = $urandom_range(0, dlen);
            default: dbytes = dlen;
         endcase
      end
      repeat (dbytes) put_byte(pick_byte(), 1'b0);
   endtask

   // headerless file, sometimes opening with part of the RIFF magic
   task automatic gen_raw_file();
      int unsigned pre;
      logic [7:0]  b;
      raw_files++;
      pre = $urandom_range(0, 3);
      for (int unsigned k = 0; k < pre; k++) put_byte(RIFF_WORD[8*k +: 8], k == 0);
      b = pick_byte();
      if (b == RIFF_WORD[8*pre +: 8]) b = b ^ 8'h01;
      put_byte(b, pre == 0);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 24)) put_byte(pick_byte(), 1'b0);
   endtask

   task automatic gen_noise();
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom), $urandom_range(0, 4) == 0);
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= RATE_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_rate(input logic [wsp_pkg::SAMPLE_RATE_W-1:0] rate);
      logic [31:0] rd;
      csr_access(1'b1, {1'b0, rate}, rd);
      rate_cfg = rate;
      csr_access(1'b0, 32'h0, rd);
      if (rd !== {1'b0, rate}) begin
         $error("sample_rate readback: expected %h, got %h", {1'b0, rate}, rd);
         fail_count++;
      end
   endtask

   // wait until every byte is taken and every result has come back
   task automatic wait_drained();
      do @(posedge clock);
      while (byte_stream.size() != 0 || req_tvalid || outputs_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [wsp_pkg::SAMPLE_RATE_W-1:0] phase_rate(input int unsigned p);
      case (p)
         1:       return '0;
         2:       return '1;
         3:       return 31'd44100;
         4:       return 31'($urandom);
         default: return wsp_pkg::SAMPLE_RATE_RESET;
      endcase
   endfunction

   // main sequence
   initial begin
      int unsigned target;
      int unsigned pick;
      rate_cfg = wsp_pkg::SAMPLE_RATE_RESET;
      restart_parser();
      cur_phase = wsp_pkg::PH_IDLE;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: stray bytes, short headerless files, partial magic
      put_byte(8'hA5, 1'b0);
      put_byte(wsp_pkg::CHAR_R, 1'b0);
      put_byte(8'h00, 1'b1);
      put_byte(wsp_pkg::CHAR_R, 1'b1);
      put_byte(8'hFF, 1'b0);
      put_byte(wsp_pkg::CHAR_R, 1'b1);
      put_byte(wsp_pkg::CHAR_I, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'h7F, 1'b0);
      put_byte(8'h80, 1'b0);
      put_byte(wsp_pkg::CHAR_R, 1'b1);
      put_byte(wsp_pkg::CHAR_I, 1'b0);
      put_byte(wsp_pkg::CHAR_F, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(wsp_pkg::CHAR_R, 1'b1);
      put_byte(wsp_pkg::CHAR_I, 1'b0);
      put_byte(wsp_pkg::CHAR_F, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'h01, 1'b0);
      put_byte(8'h02, 1'b0);
      put_byte(8'hFF, 1'b1);
      put_byte(8'hFF, 1'b0);
      wait_drained();

      // random files, one rate setting per phase
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) set_rate(phase_rate(p));
         target = bytes_queued + 250;
         while (bytes_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) gen_wave_file(($urandom_range(0, 9) == 0) ? 31'($urandom) : rate_cfg);
            else if (pick < 85) gen_raw_file();
            else gen_noise();
         end
         wait_drained();
      end

      $display("covered %0d bytes over %0d rate settings: %0d RIFF and %0d headerless files",
               bytes_queued, NUM_PHASES, wave_files, raw_files);
      $display("checked %0d samples and %0d header error reports", samples_seen, errors_seen);
      if (fail_count == 0 && outputs_due.size() == 0) begin
         $display("[wav_stream_parser] OK");
      end else begin
         $display("[wav_stream_parser] ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #8000000;
      $display("[wav_stream_parser] ERROR");
      $finish;
   end

endmodule
